/* design/tcs_pkg.sv */
// Shared types and constants for the text console with scroll.
// Used by the screen RAM and by the console core top level.
`default_nettype none

package tcs_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = ATTR_W + CHAR_W;
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

endpackage

`default_nettype wire

/* design/tcs_screen_ram.sv */
// Screen cell store: one write port and one registered read port.
// Depends on tcs_pkg for the cell width.
`default_nettype none

module tcs_screen_ram
   import tcs_pkg::*;
#(
   parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
   parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [CELL_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/text_console_with_scroll_core.sv */
// Text console core: a put or unused-opcode beat gives a registered result after acceptance;
// a read beat's result passes the RAM read register, then the response register. A put that
// scrolls makes one screen pass through the single RAM write port; a clear refills every cell.
// After reset the core blanks the screen RAM with attribute 0x07 and
// holds req_stall high meanwhile; attribute writes are taken at any time.
// Depends on tcs_pkg and tcs_screen_ram.
`default_nettype none

module text_console_with_scroll_core
   import tcs_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic [CHAR_W-1:0]   req_char_code,
   input  wire logic [INDEX_W-1:0]  req_cell_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CELL_W-1:0]        rsp_cell_value,
   output logic [CURSOR_W-1:0]      rsp_cursor_position,
   output logic                     rsp_scrolled,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [ATTR_W-1:0]   csr_text_attribute
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int CMP_W      = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(CELL_COUNT - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP       = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW       = ROW_W'(ROWS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_FILL
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic [ADDR_W-1:0]   dst_ff, dst_in;
   logic                pend_ff, pend_in;
   logic                emit_ff, emit_in;
   logic                scroll_flag_ff, scroll_flag_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [ATTR_W-1:0]   fill_attr_ff, fill_attr_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [ADDR_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]   rsp_cell_ff, rsp_cell_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic                rsp_scrolled_ff, rsp_scrolled_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CELL_W-1:0]   wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CELL_W-1:0]   rd_data;

   logic                accept;
   logic                is_nl;
   logic                is_cr;
   logic                col_last;
   logic                row_last;
   logic                wrap;
   logic                rd_ok;
   logic [ADDR_W-1:0]   row_start;
   logic [ADDR_W-1:0]   next_row_start;

   tcs_screen_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign is_nl          = (req_char_code == CH_NEWLINE);
   assign is_cr          = (req_char_code == CH_RETURN);
   assign col_last       = (cur_col_ff == LAST_COL);
   assign row_last       = (cur_row_ff == LAST_ROW);
   assign wrap           = is_nl || (!is_cr && col_last);
   assign rd_ok          = CMP_W'(req_cell_index) < CMP_W'(CELL_COUNT);
   assign row_start      = cur_idx_ff - ADDR_W'(cur_col_ff);
   assign next_row_start = row_start + ROW_STEP;

   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      dst_in          = dst_ff;
      pend_in         = pend_ff;
      emit_in         = emit_ff;
      scroll_flag_in  = scroll_flag_ff;
      rd_ok_in        = rd_ok_ff;
      fill_attr_in    = fill_attr_ff;
      attr_in         = csr_valid ? csr_text_attribute : attr_ff;
      cur_idx_in      = cur_idx_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_cell_in     = rsp_cell_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      wr_en           = 1'b0;
      wr_addr         = ptr_ff;
      wr_data         = {fill_attr_ff, CH_SPACE};
      rd_en           = 1'b0;
      rd_addr         = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_PUT: begin
                     if (!is_nl && !is_cr) begin
                        wr_en   = 1'b1;
                        wr_addr = cur_idx_ff;
                        wr_data = {attr_ff, req_char_code};
                     end
                     if (is_cr) begin
                        cur_idx_in = row_start;
                        cur_col_in = '0;
                     end else if (wrap) begin
                        cur_col_in = '0;
                        if (row_last) begin
                           cur_idx_in     = row_start;
                           state_in       = ST_SCROLL;
                           ptr_in         = ROW_STEP;
                           pend_in        = 1'b0;
                           fill_attr_in   = attr_ff;
                           emit_in        = 1'b1;
                           scroll_flag_in = 1'b1;
                        end else begin
                           cur_row_in = cur_row_ff + ROW_W'(1);
                           cur_idx_in = next_row_start;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + COL_W'(1);
                        cur_idx_in = cur_idx_ff + ADDR_W'(1);
                     end
                     if (!(wrap && row_last)) begin
                        rsp_valid_in    = 1'b1;
                        rsp_cell_in     = '0;
                        rsp_cursor_in   = CURSOR_W'(cur_idx_in);
                        rsp_scrolled_in = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     cur_idx_in     = '0;
                     cur_col_in     = '0;
                     cur_row_in     = '0;
                     state_in       = ST_FILL;
                     ptr_in         = '0;
                     fill_attr_in   = attr_ff;
                     emit_in        = 1'b1;
                     scroll_flag_in = 1'b0;
                  end
                  OP_READ: begin
                     rd_en    = rd_ok;
                     rd_addr  = ADDR_W'(req_cell_index);
                     rd_ok_in = rd_ok;
                     state_in = ST_READ;
                  end
                  default: begin
                     rsp_valid_in    = 1'b1;
                     rsp_cell_in     = '0;
                     rsp_cursor_in   = CURSOR_W'(cur_idx_ff);
                     rsp_scrolled_in = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in    = 1'b1;
            rsp_cell_in     = rd_ok_ff ? rd_data : '0;
            rsp_cursor_in   = CURSOR_W'(cur_idx_ff);
            rsp_scrolled_in = 1'b0;
            state_in        = ST_IDLE;
         end
         ST_SCROLL: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff;
            wr_en   = pend_ff;
            wr_addr = dst_ff;
            wr_data = rd_data;
            pend_in = 1'b1;
            dst_in  = ptr_ff - ROW_STEP;
            if (ptr_ff == LAST_CELL) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            wr_en    = 1'b1;
            wr_addr  = dst_ff;
            wr_data  = rd_data;
            ptr_in   = LAST_ROW_START;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
               if (emit_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_cell_in     = '0;
                  rsp_cursor_in   = CURSOR_W'(cur_idx_ff);
                  rsp_scrolled_in = scroll_flag_ff;
               end
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FILL;
         ptr_ff         <= '0;
         pend_ff        <= 1'b0;
         emit_ff        <= 1'b0;
         scroll_flag_ff <= 1'b0;
         fill_attr_ff   <= RESET_ATTR;
         attr_ff        <= RESET_ATTR;
         cur_idx_ff     <= '0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ptr_ff         <= ptr_in;
         pend_ff        <= pend_in;
         emit_ff        <= emit_in;
         scroll_flag_ff <= scroll_flag_in;
         fill_attr_ff   <= fill_attr_in;
         attr_ff        <= attr_in;
         cur_idx_ff     <= cur_idx_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      dst_ff          <= dst_in;
      rd_ok_ff        <= rd_ok_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_cell_ff;
   assign rsp_cursor_position = rsp_cursor_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;

endmodule

`default_nettype wire
